/* design/double_ended_queue_macros.svh */
// Assertion macros for the deque RTL.
// Depends on nothing; included by double_ended_queue, which carries concurrent assertions.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DEQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

/* design/deq_pkg.sv */
// Shared types and codes for the double-ended queue.
// Depends on nothing; used by deq_cell and double_ended_queue.
`default_nettype none

package deq_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_RIGHT,
    CELL_SHIFT_LEFT,
    CELL_LOAD_BACK,
    CELL_COLLECT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COLLECT,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

/* design/double_ended_queue.sv */
// Double-ended queue top level: control, occupancy count and a row of deq_cell.
// Depends on deq_pkg, deq_cell and double_ended_queue_macros.svh.
// Push front/back, pop front and peek front: result in the cycle after accept, next item then.
// Pop back and peek back: result after the collect and finish states, set by the collect chain.
// Errors and unused action codes answer in the cycle after accept. Receiver cannot stall the results.
// Synchronous active-high reset empties the queue; stored words are not cleared.
`default_nettype none
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [2:0]  action,
  input  wire  [31:0] value_in,
  output logic        busy,
  output logic        done,
  output logic [31:0] value_out,
  output logic [1:0]  status,
  output logic        is_empty,
  output logic [4:0]  occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  // The front of the queue always sits in cell 0 and the back in cell count-1.
  // Front operations shift the whole row by one cell; push back writes the cell
  // whose index equals the count. A back read has no fixed cell, so a collect
  // chain walks the back word down to cell 0, one cell per cycle.

  deq_pkg::state_t     state;
  deq_pkg::state_t     state_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       wait_cnt;
  logic                back_pop;
  deq_pkg::cell_ctrl_t ctrl;

  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_pass [DEPTH];

  logic                  accept;
  deq_pkg::action_t      act;
  logic                  full;
  logic                  empty;
  logic                  res_valid;
  logic [DATA_WIDTH-1:0] res_value;
  deq_pkg::status_t      res_status;

  assign word   = DATA_WIDTH'(value_in);
  assign act    = deq_pkg::action_t'(action);
  assign accept = start && (state == deq_pkg::S_IDLE);
  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);

  // Cell row.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    logic [DATA_WIDTH-1:0] right_p;
    if (i == 0) begin : g_first
      assign left_d = word;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
      assign right_p = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
      assign right_p = cell_pass[i+1];
    end
    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .COUNT_WIDTH(CW),
      .INDEX      (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .word      (word),
      .left_data (left_d),
      .right_data(right_d),
      .right_pass(right_p),
      .data      (cell_data[i]),
      .pass      (cell_pass[i])
    );
  end

  // Next state: only a back read of a non-empty queue leaves idle.
  always_comb begin
    state_next = state;
    case (state)
      deq_pkg::S_IDLE: begin
        if (accept && !empty &&
            (act == deq_pkg::ACT_POP_BACK || act == deq_pkg::ACT_PEEK_BACK)) begin
          state_next = deq_pkg::S_COLLECT;
        end
      end
      deq_pkg::S_COLLECT: begin
        if (wait_cnt == CW'(1)) state_next = deq_pkg::S_FINISH;
      end
      deq_pkg::S_FINISH: state_next = deq_pkg::S_IDLE;
      default: state_next = deq_pkg::S_IDLE;
    endcase
  end

  // Outputs of the control: cell operation, new count and the result to register.
  always_comb begin
    busy       = (state != deq_pkg::S_IDLE);
    ctrl.op    = deq_pkg::CELL_HOLD;
    count_next = count;
    res_valid  = 1'b0;
    res_value  = '0;
    res_status = deq_pkg::STATUS_OK;
    case (state)
      deq_pkg::S_IDLE: begin
        if (accept) begin
          res_valid = 1'b1;
          case (act)
            deq_pkg::ACT_PUSH_FRONT: begin
              if (full) begin
                res_status = deq_pkg::STATUS_FULL;
              end else begin
                ctrl.op    = deq_pkg::CELL_SHIFT_RIGHT;
                count_next = count + CW'(1);
              end
            end
            deq_pkg::ACT_PUSH_BACK: begin
              if (full) begin
                res_status = deq_pkg::STATUS_FULL;
              end else begin
                ctrl.op    = deq_pkg::CELL_LOAD_BACK;
                count_next = count + CW'(1);
              end
            end
            deq_pkg::ACT_POP_FRONT: begin
              if (empty) begin
                res_status = deq_pkg::STATUS_EMPTY;
              end else begin
                res_value  = cell_data[0];
                ctrl.op    = deq_pkg::CELL_SHIFT_LEFT;
                count_next = count - CW'(1);
              end
            end
            deq_pkg::ACT_PEEK_FRONT: begin
              if (empty) res_status = deq_pkg::STATUS_EMPTY;
              else res_value = cell_data[0];
            end
            deq_pkg::ACT_POP_BACK, deq_pkg::ACT_PEEK_BACK: begin
              // A non-empty back read answers later, from the collect chain.
              if (empty) res_status = deq_pkg::STATUS_EMPTY;
              else res_valid = 1'b0;
            end
            default: ;
          endcase
        end
      end
      deq_pkg::S_COLLECT: ctrl.op = deq_pkg::CELL_COLLECT;
      deq_pkg::S_FINISH: begin
        res_valid = 1'b1;
        res_value = cell_pass[0];
        if (back_pop) count_next = count - CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= res_valid;
    end
  end

  // Collect bookkeeping and the result word need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      wait_cnt <= count;
      back_pop <= (act == deq_pkg::ACT_POP_BACK);
    end else if (state == deq_pkg::S_COLLECT) begin
      wait_cnt <= wait_cnt - CW'(1);
    end
    if (res_valid) begin
      value_out <= 32'(res_value);
      status    <= res_status;
      is_empty  <= (count_next == '0);
      occupancy <= 5'(count_next);
    end
  end

  logic full_push;
  assign full_push = accept && full &&
                     (act == deq_pkg::ACT_PUSH_FRONT || act == deq_pkg::ACT_PUSH_BACK);

  `DEQ_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `DEQ_ASSERT_IMP(a_collect_wait, clk, rst, state == deq_pkg::S_COLLECT, wait_cnt != '0)
  `DEQ_ASSERT_NEXT(a_finish_done, clk, rst, state == deq_pkg::S_FINISH, done && !busy)
  `DEQ_ASSERT_NEXT(a_full_push, clk, rst, full_push, done && status == deq_pkg::STATUS_FULL && $stable(count))

endmodule

`default_nettype wire

/* design/deq_cell.sv */
// One storage cell of the deque chain: holds one word and one collect stage.
// Depends on deq_pkg for the cell control struct.
`default_nettype none

module deq_cell #(
  parameter int DATA_WIDTH  = 32,
  parameter int COUNT_WIDTH = 5,
  parameter int INDEX       = 0
) (
  input  wire                    clk,
  input  wire deq_pkg::cell_ctrl_t ctrl,
  input  wire [COUNT_WIDTH-1:0]  count,
  input  wire [DATA_WIDTH-1:0]   word,
  input  wire [DATA_WIDTH-1:0]   left_data,
  input  wire [DATA_WIDTH-1:0]   right_data,
  input  wire [DATA_WIDTH-1:0]   right_pass,
  output logic [DATA_WIDTH-1:0]  data,
  output logic [DATA_WIDTH-1:0]  pass
);

  logic [DATA_WIDTH-1:0] data_next;
  logic [DATA_WIDTH-1:0] pass_next;

  always_comb begin
    data_next = data;
    pass_next = pass;
    case (ctrl.op)
      deq_pkg::CELL_SHIFT_RIGHT: data_next = left_data;
      deq_pkg::CELL_SHIFT_LEFT:  data_next = right_data;
      deq_pkg::CELL_LOAD_BACK: begin
        if (count == COUNT_WIDTH'(INDEX)) data_next = word;
      end
      // The back cell injects its word; every other cell forwards toward cell 0.
      deq_pkg::CELL_COLLECT: begin
        pass_next = (count == COUNT_WIDTH'(INDEX + 1)) ? data : right_pass;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    pass <= pass_next;
  end

endmodule

`default_nettype wire
